// ===== hdl/i2c_master_transaction_sequencer_macros.svh =====
// Assertion macros shared by the checkers of the I2C sequencer.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define I2CMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and sizes shared by the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

	// Transmit buffer size
	localparam int TX_DEPTH = 16;
	localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam logic [4:0] TX_LIMIT = 5'(TX_DEPTH);

	// Command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Input item modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_EVENT = 2'd2;

	// Transfer modes
	localparam logic [1:0] XFER_WRITE = 2'd0;
	localparam logic [1:0] XFER_READ  = 2'd1;
	localparam logic [1:0] XFER_WR_RD = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_WR_NACK  = 2'd1;
	localparam logic [1:0] ERR_ARB_LOST = 2'd2;
	localparam logic [1:0] ERR_RD_NACK  = 2'd3;

	// Engine status codes
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	localparam logic [7:0] READ_BIT = 8'h01;
	localparam logic [7:0] FILLER   = 8'hFF;

	// Register indexes
	localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] REG_XFER_MODE  = 2'd1;
	localparam logic [1:0] REG_TX_COUNT   = 2'd2;
	localparam logic [1:0] REG_RX_COUNT   = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] tx_index;
		logic [7:0] tx_byte;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
	} item_t;

	typedef struct packed {
		logic       data_write_valid;
		logic [7:0] data_write;
		logic       start_set;
		logic       start_clear;
		logic       stop_set;
		logic       ack_set;
		logic       ack_clear;
		logic       done_res;
		logic [1:0] error_code;
		logic       rx_store_valid;
		logic [7:0] rx_store_byte;
		logic [7:0] rx_store_index;
	} result_t;

	// Configuration register file
	typedef struct packed {
		logic [7:0] slave_address;
		logic [1:0] transfer_mode;
		logic [4:0] tx_count;
		logic [7:0] rx_count;
	} cfg_t;

	// Classified command kinds
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_START,
		CMD_ADDR,
		CMD_FILLER,
		CMD_ADVANCE,
		CMD_FINISH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [1:0] err;
		logic [3:0] idx;
		logic [7:0] byte_val;
	} cmd_t;

	// Queue status toward producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hdl/i2cms_front.sv =====
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts input items and classifies them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_front (
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire i2cms_pkg::item_t  item,
	input  wire i2cms_pkg::q_status_t q_stat,
	output logic                   push,
	output i2cms_pkg::cmd_t        push_cmd
);
	import i2cms_pkg::*;

	// Take an item whenever the queue has room
	assign item_ready = !q_stat.full;
	assign push       = item_valid && item_ready;

	// Classify mode and status code
	always_comb begin
		push_cmd.kind     = CMD_NOP;
		push_cmd.err      = ERR_NONE;
		push_cmd.idx      = item.tx_index;
		push_cmd.byte_val = item.tx_byte;
		case (item.mode)
			MODE_LOAD: begin
				if (32'(item.tx_index) < TX_DEPTH)
					push_cmd.kind = CMD_LOAD;
			end
			MODE_START: push_cmd.kind = CMD_START;
			MODE_EVENT: begin
				push_cmd.byte_val = item.bus_data;
				case (item.bus_status)
					ST_START, ST_RESTART: push_cmd.kind = CMD_ADDR;
					ST_SLA_R_ACK: push_cmd.kind = CMD_FILLER;
					ST_SLA_W_ACK, ST_DATA_W_ACK, ST_DATA_R_ACK: push_cmd.kind = CMD_ADVANCE;
					ST_SLA_W_NACK: begin
						push_cmd.kind = CMD_FINISH;
						push_cmd.err  = ERR_WR_NACK;
					end
					ST_ARB_LOST: begin
						push_cmd.kind = CMD_FINISH;
						push_cmd.err  = ERR_ARB_LOST;
					end
					ST_SLA_R_NACK: begin
						push_cmd.kind = CMD_FINISH;
						push_cmd.err  = ERR_RD_NACK;
					end
					ST_DATA_R_NACK: push_cmd.kind = CMD_FINISH;
					default: push_cmd.kind = CMD_NOP;
				endcase
			end
			default: push_cmd.kind = CMD_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/i2cms_queue.sv =====
// ----------------------------------------------------------------------------
// i2cms_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire i2cms_pkg::cmd_t     push_cmd,
	input  wire logic                pop,
	output i2cms_pkg::cmd_t          pop_cmd,
	output i2cms_pkg::q_status_t     q_stat
);
	import i2cms_pkg::*;

	cmd_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	function automatic logic [Q_AW-1:0] ptr_next(input logic [Q_AW-1:0] p);
		ptr_next = (32'(p) == Q_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	assign q_stat.full  = (32'(count_q) == Q_DEPTH);
	assign q_stat.empty = (count_q == '0);
	assign pop_cmd      = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Payload slots
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ===== hdl/i2cms_back.sv =====
// ----------------------------------------------------------------------------
// i2cms_back
// Executes queued commands: transaction state, transmit buffer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2cms_pkg::cfg_t      cfg,
	input  wire i2cms_pkg::q_status_t q_stat,
	input  wire i2cms_pkg::cmd_t      q_cmd,
	output logic                      q_pop,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output i2cms_pkg::result_t        result
);
	import i2cms_pkg::*;

	logic [7:0] tx_buf_q [TX_DEPTH];
	logic [4:0] tx_pos_q;
	logic [7:0] rx_pos_q;
	logic [1:0] act_mode_q;
	logic [7:0] act_addr_q;
	logic       done_q;
	logic       out_valid_q;
	result_t    out_q;

	logic [4:0] tx_pos_d;
	logic [7:0] rx_pos_d;
	logic [1:0] act_mode_d;
	logic [7:0] act_addr_d;
	logic       done_d;
	result_t    res_d;
	logic [4:0] tx_limit;
	logic       can_send;
	logic [7:0] tx_head;

	// Pop when the result register is free or being emptied
	assign q_pop        = !q_stat.empty && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign tx_limit = (cfg.tx_count > TX_LIMIT) ? TX_LIMIT : cfg.tx_count;
	assign can_send = (tx_pos_q < tx_limit);
	assign tx_head  = tx_buf_q[tx_pos_q[TX_AW-1:0]];

	// Command execution
	always_comb begin
		tx_pos_d   = tx_pos_q;
		rx_pos_d   = rx_pos_q;
		act_mode_d = act_mode_q;
		act_addr_d = act_addr_q;
		done_d     = done_q;
		res_d      = '0;
		case (q_cmd.kind)
			CMD_START: begin
				act_mode_d = cfg.transfer_mode;
				act_addr_d = (cfg.transfer_mode == XFER_READ) ?
					(cfg.slave_address | READ_BIT) : cfg.slave_address;
				tx_pos_d = '0;
				rx_pos_d = '0;
				done_d   = 1'b0;
				res_d.start_set = 1'b1;
			end
			CMD_ADDR: begin
				res_d.data_write_valid = 1'b1;
				res_d.data_write       = act_addr_q;
				res_d.start_clear      = 1'b1;
			end
			CMD_FILLER: begin
				res_d.data_write_valid = 1'b1;
				res_d.data_write       = FILLER;
			end
			CMD_FINISH: begin
				done_d           = 1'b1;
				res_d.stop_set   = 1'b1;
				res_d.error_code = q_cmd.err;
			end
			CMD_ADVANCE: begin
				case (act_mode_q)
					XFER_WRITE, XFER_WR_RD: begin
						if (can_send) begin
							res_d.data_write_valid = 1'b1;
							res_d.data_write       = tx_head;
							tx_pos_d               = tx_pos_q + 5'd1;
						end else if (act_mode_q == XFER_WRITE) begin
							done_d         = 1'b1;
							res_d.stop_set = 1'b1;
						end else begin
							// Turn around into the read phase
							act_mode_d      = XFER_READ;
							act_addr_d      = act_addr_q | READ_BIT;
							res_d.start_set = 1'b1;
						end
					end
					XFER_READ: begin
						if (rx_pos_q < cfg.rx_count) begin
							res_d.rx_store_valid = 1'b1;
							res_d.rx_store_byte  = q_cmd.byte_val;
							res_d.rx_store_index = rx_pos_q;
							rx_pos_d             = rx_pos_q + 8'd1;
							res_d.ack_set        = 1'b1;
						end else begin
							res_d.ack_clear = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		res_d.done_res = done_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_pos_q    <= '0;
			rx_pos_q    <= '0;
			act_mode_q  <= XFER_WRITE;
			act_addr_q  <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				tx_pos_q   <= tx_pos_d;
				rx_pos_q   <= rx_pos_d;
				act_mode_q <= act_mode_d;
				act_addr_q <= act_addr_d;
				done_q     <= done_d;
			end
			if (q_pop)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result register and transmit buffer
	always_ff @(posedge clk) begin
		if (q_pop)
			out_q <= res_d;
		if (q_pop && q_cmd.kind == CMD_LOAD)
			tx_buf_q[TX_AW'(q_cmd.idx)] <= q_cmd.byte_val;
	end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Turns I2C engine status codes into data writes and bus commands.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): load a transmit byte, start a
//   transaction, or report an engine status code with its data byte.
//   result channel (result_valid/result_ready/result): one transfer per item,
//   with the byte to load, start/stop/ack commands, a received byte, done
//   and error code.
//   APB port: slave_address, transfer_mode, tx_count, rx_count at byte
//   addresses 0, 4, 8, 12; write only while no item is in flight.
// Path: an accepted item is written into the command queue, then popped
//   and executed into the result register, where it is held with
//   result_valid high until taken.
// Throughput: one item per cycle while result_ready keeps the result
//   register draining; the back part updates the transaction state per pop.
// Reset: clears the registers, positions, mode, address, done flag and the
//   queue; the transmit buffer holds no defined value until written.
// Stall: while result_ready is low the result is held; the two-entry command
//   queue takes up to two more items, then item_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire i2cms_pkg::item_t   item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output i2cms_pkg::result_t      result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import i2cms_pkg::*;

	cfg_t      cfg_q;
	q_status_t q_stat;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      pop_cmd;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_SLAVE_ADDR: cfg_q.slave_address <= pwdata[7:0];
				REG_XFER_MODE:  cfg_q.transfer_mode <= pwdata[1:0];
				REG_TX_COUNT:   cfg_q.tx_count      <= pwdata[4:0];
				REG_RX_COUNT:   cfg_q.rx_count      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			REG_SLAVE_ADDR: prdata = {24'd0, cfg_q.slave_address};
			REG_XFER_MODE:  prdata = {30'd0, cfg_q.transfer_mode};
			REG_TX_COUNT:   prdata = {27'd0, cfg_q.tx_count};
			REG_RX_COUNT:   prdata = {24'd0, cfg_q.rx_count};
			default:        prdata = '0;
		endcase
	end

	i2cms_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	i2cms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	i2cms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.q_cmd        (pop_cmd),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== hdl/i2cms_checker.sv =====
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_transaction_sequencer_macros.svh"

module i2cms_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire i2cms_pkg::result_t result
);
	import i2cms_pkg::*;

	// A stalled transfer holds
	`I2CMS_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	// No data byte without its valid flag
	`I2CMS_ASSERT_NOW(a_dw_zero, result_valid && !result.data_write_valid, result.data_write == 8'd0, "data_write set without valid")

	// An error always ends the transaction
	`I2CMS_ASSERT_NOW(a_err_stop, result_valid && result.error_code != ERR_NONE, result.stop_set && result.done_res, "error without stop and done")

	// Received byte fields stay clear when nothing is delivered
	`I2CMS_ASSERT_NOW(a_rx_zero, result_valid && !result.rx_store_valid, result.rx_store_byte == 8'd0 && result.rx_store_index == 8'd0, "rx fields set without valid")

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master transaction sequencer. A queue of
// stimulus items (buffer loads, transaction starts, engine status events) is
// fed through the item channel with random gaps, results are drained with
// random stalls, and every result transfer is compared field by field with
// an in-bench prediction of the sequencer's state machine. Configuration is
// changed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import i2cms_pkg::*;

	// Codes with no package name: ignored item mode, undefined transfer mode
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [1:0] XFER_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1950;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	i2c_master_transaction_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stimulus and expected results
	item_t   pend_items[$];
	result_t expected_results[$];
	int      err_count = 0;
	int      gen_count = 0;
	int      cycle_count = 0;
	bit      loaded [TX_DEPTH];

	// Handshake history seen at the last rising edge
	logic item_fire = 1'b0;
	logic res_fire = 1'b0;

	// Configuration copy
	logic [7:0] cfg_addr = '0;
	logic [1:0] cfg_mode = XFER_WRITE;
	logic [4:0] cfg_txc = '0;
	logic [7:0] cfg_rxc = '0;

	// Sequencer state copy
	logic [7:0] tx_buf [TX_DEPTH];
	logic [4:0] tx_pos = '0;
	logic [7:0] rx_pos = '0;
	logic [1:0] act_mode = XFER_WRITE;
	logic [7:0] act_addr = '0;
	logic       done_q = 1'b0;

	// Next sequencer command for one accepted item; updates the state copy
	function automatic result_t sequencer_step(input item_t it);
		result_t r;
		logic [4:0] lim;
		logic advanced;
		r = '0;
		advanced = 1'b0;
		lim = (cfg_txc > TX_LIMIT) ? TX_LIMIT : cfg_txc;
		case (it.mode)
			MODE_LOAD: begin
				tx_buf[it.tx_index] = it.tx_byte;
			end
			MODE_START: begin
				act_mode = cfg_mode;
				act_addr = (cfg_mode == XFER_READ) ? (cfg_addr | READ_BIT) : cfg_addr;
				tx_pos = '0;
				rx_pos = '0;
				done_q = 1'b0;
				r.start_set = 1'b1;
			end
			MODE_EVENT: begin
				case (it.bus_status)
					ST_START, ST_RESTART: begin
						r.data_write_valid = 1'b1;
						r.data_write = act_addr;
						r.start_clear = 1'b1;
					end
					ST_SLA_R_ACK: begin
						r.data_write_valid = 1'b1;
						r.data_write = FILLER;
					end
					ST_SLA_W_ACK, ST_DATA_W_ACK, ST_DATA_R_ACK: begin
						advanced = 1'b1;
					end
					ST_SLA_W_NACK: begin
						done_q = 1'b1;
						r.stop_set = 1'b1;
						r.error_code = ERR_WR_NACK;
					end
					ST_ARB_LOST: begin
						done_q = 1'b1;
						r.stop_set = 1'b1;
						r.error_code = ERR_ARB_LOST;
					end
					ST_SLA_R_NACK: begin
						done_q = 1'b1;
						r.stop_set = 1'b1;
						r.error_code = ERR_RD_NACK;
					end
					ST_DATA_R_NACK: begin
						done_q = 1'b1;
						r.stop_set = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// Transfer advance: next buffer byte, next received byte, or turnaround
		if (advanced) begin
			case (act_mode)
				XFER_WRITE, XFER_WR_RD: begin
					if (tx_pos < lim) begin
						r.data_write_valid = 1'b1;
						r.data_write = tx_buf[tx_pos[3:0]];
						tx_pos = tx_pos + 5'd1;
					end else if (act_mode == XFER_WRITE) begin
						done_q = 1'b1;
						r.stop_set = 1'b1;
					end else begin
						act_mode = XFER_READ;
						act_addr = act_addr | READ_BIT;
						r.start_set = 1'b1;
					end
				end
				XFER_READ: begin
					if (rx_pos < cfg_rxc) begin
						r.rx_store_valid = 1'b1;
						r.rx_store_byte = it.bus_data;
						r.rx_store_index = rx_pos;
						rx_pos = rx_pos + 8'd1;
						r.ack_set = 1'b1;
					end else begin
						r.ack_clear = 1'b1;
					end
				end
				default: ;
			endcase
		end
		r.done_res = done_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endtask

	// Monitor: predict on item transfer, check on result transfer
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			item_fire <= item_valid && item_ready;
			res_fire <= result_valid && result_ready;
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no expected result");
					err_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("data_write_valid", 8'(want.data_write_valid),
						8'(result.data_write_valid));
					check_field("data_write", want.data_write, result.data_write);
					check_field("start_set", 8'(want.start_set), 8'(result.start_set));
					check_field("start_clear", 8'(want.start_clear),
						8'(result.start_clear));
					check_field("stop_set", 8'(want.stop_set), 8'(result.stop_set));
					check_field("ack_set", 8'(want.ack_set), 8'(result.ack_set));
					check_field("ack_clear", 8'(want.ack_clear), 8'(result.ack_clear));
					check_field("done_res", 8'(want.done_res), 8'(result.done_res));
					check_field("error_code", 8'(want.error_code),
						8'(result.error_code));
					check_field("rx_store_valid", 8'(want.rx_store_valid),
						8'(result.rx_store_valid));
					check_field("rx_store_byte", want.rx_store_byte, result.rx_store_byte);
					check_field("rx_store_index", want.rx_store_index,
						result.rx_store_index);
				end
			end
			if (item_valid && item_ready)
				expected_results.push_back(sequencer_step(item));
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Item driver: random gap after each transfer, with burst stretches
	int in_gap = 0;
	bit in_burst = 1'b0;
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_fire)) begin
			if (in_gap > 0) begin
				item_valid <= 1'b0;
				in_gap--;
			end else if (pend_items.size() != 0) begin
				item <= pend_items.pop_front();
				item_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					in_burst = !in_burst;
				in_gap = in_burst ? 0 : $urandom_range(0, 15);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result sink: random stall after each transfer, with burst stretches
	int out_wait = 0;
	bit out_burst = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire) begin
				if ($urandom_range(0, 39) == 0)
					out_burst = !out_burst;
				out_wait = out_burst ? 0 : $urandom_range(0, 15);
			end
			if (out_wait > 0) begin
				result_ready <= 1'b0;
				out_wait--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// APB write: setup, access until pready, then release
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SLAVE_ADDR: cfg_addr = val[7:0];
			REG_XFER_MODE:  cfg_mode = val[1:0];
			REG_TX_COUNT:   cfg_txc = val[4:0];
			REG_RX_COUNT:   cfg_rxc = val[7:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pend_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// idx < 0 picks a random buffer position
	task automatic queue_item(input logic [1:0] m, input logic [7:0] st, input int idx);
		item_t it;
		it.mode = m;
		it.tx_index = (idx < 0) ? 4'($urandom_range(0, 15)) : 4'(idx);
		it.tx_byte = 8'($urandom);
		it.bus_status = st;
		it.bus_data = 8'($urandom);
		if (m == MODE_LOAD)
			loaded[it.tx_index] = 1'b1;
		if (m != MODE_NONE)
			gen_count++;
		pend_items.push_back(it);
	endtask

	function automatic logic [7:0] ack_code(input logic [7:0] usual);
		case ($urandom_range(0, 19))
			0: return ST_SLA_W_ACK;
			1: return ST_DATA_W_ACK;
			2: return ST_DATA_R_ACK;
			default: return usual;
		endcase
	endfunction

	function automatic logic [7:0] end_code();
		case ($urandom_range(0, 3))
			0: return ST_SLA_W_NACK;
			1: return ST_ARB_LOST;
			2: return ST_SLA_R_NACK;
			default: return ST_DATA_R_NACK;
		endcase
	endfunction

	// Half known codes, half arbitrary bytes
	function automatic logic [7:0] noise_code();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom);
		case ($urandom_range(0, 9))
			0: return ST_START;
			1: return ST_RESTART;
			2: return ST_SLA_W_ACK;
			3: return ST_SLA_W_NACK;
			4: return ST_DATA_W_ACK;
			5: return ST_ARB_LOST;
			6: return ST_SLA_R_ACK;
			7: return ST_SLA_R_NACK;
			8: return ST_DATA_R_ACK;
			default: return ST_DATA_R_NACK;
		endcase
	endfunction

	// One well-formed transaction for the current mode, sometimes cut short
	task automatic queue_transaction();
		int lim;
		int n;
		int pick;
		lim = (cfg_txc > TX_DEPTH) ? TX_DEPTH : cfg_txc;
		pick = $urandom_range(0, 99);
		repeat ($urandom_range(0, 2)) queue_item(MODE_LOAD, 8'($urandom), -1);
		queue_item(MODE_START, 8'($urandom), -1);
		queue_item(MODE_EVENT, ST_START, -1);
		if (pick < 8) begin
			queue_item(MODE_EVENT, end_code(), -1);
			return;
		end
		if (cfg_mode == XFER_NONE) begin
			repeat ($urandom_range(1, 6)) queue_item(MODE_EVENT, ack_code(ST_DATA_W_ACK), -1);
			return;
		end

		// Write part
		if (cfg_mode == XFER_WRITE || cfg_mode == XFER_WR_RD) begin
			queue_item(MODE_EVENT, ST_SLA_W_ACK, -1);
			n = (pick < 80) ? lim : $urandom_range(0, lim + 1);
			repeat (n) queue_item(MODE_EVENT, ack_code(ST_DATA_W_ACK), -1);
			if (pick >= 80 && pick < 90) begin
				queue_item(MODE_EVENT, end_code(), -1);
				return;
			end
			if (cfg_mode == XFER_WRITE)
				return;
			queue_item(MODE_EVENT, ST_RESTART, -1);
		end

		// Read part
		queue_item(MODE_EVENT, ST_SLA_R_ACK, -1);
		if ($urandom_range(0, 7) == 0)
			n = cfg_rxc + 1;
		else
			n = $urandom_range(0, (cfg_rxc < 11) ? cfg_rxc + 1 : 12);
		repeat (n) queue_item(MODE_EVENT, ack_code(ST_DATA_R_ACK), -1);
		queue_item(MODE_EVENT, ST_DATA_R_NACK, -1);
	endtask

	// Reconfigure while idle, preload the buffer range in use, then run
	task automatic run_phase(input logic [7:0] addr, input logic [1:0] xmode,
		input logic [4:0] txc, input logic [7:0] rxc, input int n_items);
		int lim;
		int stop_at;
		wait_idle();
		write_reg(REG_SLAVE_ADDR, {24'($urandom), addr});
		write_reg(REG_XFER_MODE, {30'($urandom), xmode});
		write_reg(REG_TX_COUNT, {27'($urandom), txc});
		write_reg(REG_RX_COUNT, {24'($urandom), rxc});
		lim = (txc > TX_DEPTH) ? TX_DEPTH : txc;
		for (int i = 0; i < lim; i++) begin
			if (!loaded[i])
				queue_item(MODE_LOAD, 8'($urandom), i);
		end
		stop_at = gen_count + n_items;
		while (gen_count < stop_at) begin
			queue_transaction();
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 3))
					queue_item(2'($urandom_range(0, 3)), noise_code(), -1);
			end
		end
	endtask

	initial begin
		logic [1:0] xm;
		logic [4:0] tc;
		logic [7:0] rc;
		int budget;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings (write only, empty buffer range), every code
		queue_item(MODE_NONE, ST_START, -1);
		queue_item(MODE_EVENT, 8'h00, -1);
		queue_item(MODE_EVENT, 8'hFF, -1);
		queue_item(MODE_LOAD, 8'h00, 0);
		queue_item(MODE_LOAD, 8'hFF, 15);
		queue_item(MODE_START, 8'h00, -1);
		queue_item(MODE_EVENT, ST_START, -1);
		queue_item(MODE_EVENT, ST_SLA_W_ACK, -1);
		// events after done are still processed
		queue_item(MODE_EVENT, ST_DATA_W_ACK, -1);
		queue_item(MODE_EVENT, ST_DATA_R_ACK, -1);
		queue_item(MODE_EVENT, ST_RESTART, -1);
		queue_item(MODE_EVENT, ST_SLA_R_ACK, -1);
		queue_item(MODE_EVENT, ST_SLA_W_NACK, -1);
		queue_item(MODE_EVENT, ST_ARB_LOST, -1);
		queue_item(MODE_EVENT, ST_SLA_R_NACK, -1);
		queue_item(MODE_EVENT, ST_DATA_R_NACK, -1);
		queue_item(MODE_START, 8'hFF, -1);
		queue_item(MODE_NONE, 8'hFF, -1);
		queue_item(MODE_EVENT, ST_DATA_R_NACK, -1);

		// Extreme settings, including undefined mode and saturated count
		run_phase(8'hA4, XFER_WRITE, 5'd16, 8'd0, 120);
		run_phase(8'h00, XFER_READ, 5'd0, 8'd255, 120);
		run_phase(8'hFF, XFER_WR_RD, 5'd1, 8'd1, 120);
		run_phase(8'h5A, XFER_NONE, 5'd4, 8'd4, 60);
		run_phase(8'h3C, XFER_WRITE, 5'd31, 8'd8, 120);
		run_phase(8'h00, XFER_WR_RD, 5'd16, 8'd255, 120);
		run_phase(8'hFE, XFER_READ, 5'd16, 8'd0, 60);

		// Random settings until the item budget is spent
		while (gen_count < ITEM_TARGET) begin
			xm = ($urandom_range(0, 9) == 0) ? XFER_NONE : 2'($urandom_range(0, 2));
			tc = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, 16));
			case ($urandom_range(0, 7))
				0: rc = 8'd255;
				1: rc = 8'($urandom);
				default: rc = 8'($urandom_range(0, 16));
			endcase
			budget = ITEM_TARGET - gen_count;
			if (budget > 120)
				budget = 120;
			run_phase(8'($urandom), xm, tc, rc, budget);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
